// ===== rtl/aep_pkg.sv =====
// ----------------------------------------------------------------------------
// aep_pkg
// Shared types and codes for the audit event preselection block.
// ----------------------------------------------------------------------------
package aep_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    localparam int EVENT_W   = 16;
    localparam int CLASS_W   = 32;
    localparam int VERDICT_W = 3;

    typedef logic [EVENT_W-1:0]   event_t;
    typedef logic [CLASS_W-1:0]   class_t;
    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] SEL_SUCCESS = 2'd0;
    localparam logic [1:0] SEL_FAILURE = 2'd1;

    localparam verdict_t VERDICT_NONE     = 3'd0;
    localparam verdict_t VERDICT_PRESEL   = 3'd1;
    localparam verdict_t VERDICT_FORCED   = 3'd2;
    localparam verdict_t VERDICT_NOTFOUND = 3'd3;
    localparam verdict_t VERDICT_FULL     = 3'd4;

    typedef struct packed {
        event_t event_number;
        class_t event_class;
    } entry_t;

endpackage

// ===== rtl/audit_event_preselect.sv =====
// ----------------------------------------------------------------------------
// audit_event_preselect
// Event-to-class table with clear, append and preselection query commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. func selects clear,
// append or query; the other fields are sampled in that same cycle. Every
// command yields exactly one verdict, shown for one cycle while done is high.
// Clear and append give their verdict in the cycle after the transfer and
// never raise busy. A query walks the table from the oldest entry through the
// memory's read port, one entry per cycle, with one registered read stage in
// front of the compare; it stops at the first matching entry, or gives a
// not-found verdict once every entry below the count has been compared.
// busy stays high for the whole walk and drops in the cycle that done rises,
// so the next command can follow straight after. The receiver cannot stall.
// forced_class is written through cfg_valid/cfg_ready/cfg_data and is taken
// only while the block is not busy. Reset empties the table by clearing the
// entry count and sets forced_class to zero; the memory itself is not
// cleared, since no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
module audit_event_preselect #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              func,
    input  aep_pkg::event_t         event_number,
    input  aep_pkg::class_t         event_class,
    input  aep_pkg::class_t         success_mask,
    input  aep_pkg::class_t         failure_mask,
    input  logic [1:0]              outcome_select,
    output logic                    done,
    output aep_pkg::verdict_t       verdict,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  aep_pkg::class_t         cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    aep_pkg::entry_t   mem [TABLE_DEPTH];

    aep_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_valid_reg, chk_valid_next;
    aep_pkg::event_t   key_reg, key_next;
    aep_pkg::class_t   cmp_reg, cmp_next;
    aep_pkg::class_t   forced_reg, forced_next;
    logic              done_reg, done_next;
    aep_pkg::verdict_t verdict_reg, verdict_next;
    aep_pkg::entry_t   rd_data_reg;

    logic              accept;
    logic              issue;
    logic              wr_en;
    logic              hit;
    aep_pkg::class_t   cmp_sel;

    assign accept    = start && (state_reg == aep_pkg::ST_IDLE);
    assign busy      = (state_reg != aep_pkg::ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign verdict   = verdict_reg;

    // A read is issued while entries remain below the count.
    assign issue = (state_reg == aep_pkg::ST_SCAN) && (idx_reg < count_reg);
    assign hit   = chk_valid_reg && (rd_data_reg.event_number == key_reg);
    assign wr_en = accept && (func == aep_pkg::FUNC_APPEND) && (count_reg != DEPTH_CNT);

    always_comb
    begin
        case (outcome_select)
            aep_pkg::SEL_SUCCESS: cmp_sel = success_mask;
            aep_pkg::SEL_FAILURE: cmp_sel = failure_mask;
            default:              cmp_sel = success_mask | failure_mask;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_valid_next = 1'b0;
        key_next       = key_reg;
        cmp_next       = cmp_reg;
        forced_next    = forced_reg;
        done_next      = 1'b0;
        verdict_next   = verdict_reg;

        if (cfg_valid && cfg_ready)
        begin
            forced_next = cfg_data;
        end

        case (state_reg)
            aep_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        aep_pkg::FUNC_CLEAR:
                        begin
                            count_next   = '0;
                            done_next    = 1'b1;
                            verdict_next = aep_pkg::VERDICT_NONE;
                        end
                        aep_pkg::FUNC_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg != DEPTH_CNT)
                            begin
                                count_next   = count_reg + 1'b1;
                                verdict_next = aep_pkg::VERDICT_NONE;
                            end
                            else
                            begin
                                verdict_next = aep_pkg::VERDICT_FULL;
                            end
                        end
                        aep_pkg::FUNC_QUERY:
                        begin
                            state_next = aep_pkg::ST_SCAN;
                            idx_next   = '0;
                            key_next   = event_number;
                            cmp_next   = cmp_sel;
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            verdict_next = aep_pkg::VERDICT_NONE;
                        end
                    endcase
                end
            end
            aep_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = aep_pkg::ST_IDLE;
                    done_next  = 1'b1;
                    if ((rd_data_reg.event_class & cmp_reg) != '0)
                    begin
                        verdict_next = aep_pkg::VERDICT_PRESEL;
                    end
                    else if ((rd_data_reg.event_class & forced_reg) != '0)
                    begin
                        verdict_next = aep_pkg::VERDICT_FORCED;
                    end
                    else
                    begin
                        verdict_next = aep_pkg::VERDICT_NONE;
                    end
                end
                else if (!issue && !chk_valid_reg)
                begin
                    state_next   = aep_pkg::ST_IDLE;
                    done_next    = 1'b1;
                    verdict_next = aep_pkg::VERDICT_NOTFOUND;
                end
                else
                begin
                    chk_valid_next = issue;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = aep_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aep_pkg::ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            forced_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            forced_reg    <= forced_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        cmp_reg     <= cmp_next;
        verdict_reg <= verdict_next;
    end

    // Table memory: one write port for append, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{event_number: event_number, event_class: event_class};
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // The entry count never runs past the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count exceeds table depth");

    // Every accepted command is either answered next cycle or still being walked.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || busy))
        else $error("accepted command produced neither a verdict nor a walk");

    // A table-full verdict is only given when the table really is full.
    a_full_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (verdict_reg == aep_pkg::VERDICT_FULL)) |-> (count_reg == DEPTH_CNT))
        else $error("table-full verdict with room left in the table");

    // A walk never reads at or above the entry count.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == aep_pkg::ST_SCAN) && (idx_reg <= count_reg))
        else $error("table walk ran outside the filled entries");

endmodule
